@@ design/lssb_pkg.sv @@
// ----------------------------------------------------------------------------
// lssb_pkg
// Shared types and constants for the line support scorer: register indexes,
// reset values, Q16 slope limits and the command/status bundles.
// ----------------------------------------------------------------------------
package lssb_pkg;

    // Field widths
    localparam int COORD_W = 10;
    localparam int THICK_W = 12;
    localparam int DIM_W   = 11;
    localparam int GRAY_W  = 8;
    localparam int SCORE_W = 28;
    localparam int INDEX_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Limits of the image and of the pass count
    localparam int MAX_DIM   = 1024;
    localparam int MAX_LINES = 256;

    // Slope window, Q16 tangents of 15 and 80 degrees
    localparam int TAN15_Q16 = 17560;
    localparam int TAN80_Q16 = 371673;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_START   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_START   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_END     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_END     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THICKNESS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd6;

    // Reset values
    localparam logic [THICK_W-1:0] THICK_RESET = 12'd16;
    localparam logic [DIM_W-1:0]   DIM_RESET   = 11'd1024;

    typedef struct packed {
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic [THICK_W-1:0] thickness;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic accum;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last;
        logic out_free;
    } t_sts;

endpackage

@@ design/lssb_cfg.sv @@
// ----------------------------------------------------------------------------
// lssb_cfg
// Configuration register file: line endpoints, thickness and image size.
// ----------------------------------------------------------------------------
module lssb_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lssb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lssb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output lssb_pkg::t_cfg                    o_cfg
);

    lssb_pkg::t_cfg r_cfg;

    // Writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Decode the index and store the truncated data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_start   <= '0;
            r_cfg.y_start   <= '0;
            r_cfg.x_end     <= '0;
            r_cfg.y_end     <= '0;
            r_cfg.thickness <= lssb_pkg::THICK_RESET;
            r_cfg.width     <= lssb_pkg::DIM_RESET;
            r_cfg.height    <= lssb_pkg::DIM_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lssb_pkg::REG_X_START:   r_cfg.x_start   <= i_cfg_data[lssb_pkg::COORD_W-1:0];
                lssb_pkg::REG_Y_START:   r_cfg.y_start   <= i_cfg_data[lssb_pkg::COORD_W-1:0];
                lssb_pkg::REG_X_END:     r_cfg.x_end     <= i_cfg_data[lssb_pkg::COORD_W-1:0];
                lssb_pkg::REG_Y_END:     r_cfg.y_end     <= i_cfg_data[lssb_pkg::COORD_W-1:0];
                lssb_pkg::REG_THICKNESS: r_cfg.thickness <= i_cfg_data[lssb_pkg::THICK_W-1:0];
                lssb_pkg::REG_WIDTH:     r_cfg.width     <= i_cfg_data[lssb_pkg::DIM_W-1:0];
                lssb_pkg::REG_HEIGHT:    r_cfg.height    <= i_cfg_data[lssb_pkg::DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ design/lssb_ctrl.sv @@
// ----------------------------------------------------------------------------
// lssb_ctrl
// Sequencer: steps each pixel through the multiply, compare and accumulate
// steps of the datapath, and closes the pass on the last pixel.
// ----------------------------------------------------------------------------
module lssb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output lssb_pkg::t_cmd o_cmd,
    input  lssb_pkg::t_sts i_sts
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL1 = 6'b000010,
        S_MUL2 = 6'b000100,
        S_MUL3 = 6'b001000,
        S_ACC  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_ready        = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.accum    = 1'b0;
        o_cmd.finish   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_ACC;
            S_ACC: begin
                o_cmd.accum = 1'b1;
                n_state     = i_sts.last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                // hold until the result register is free
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/lssb_dp.sv @@
// ----------------------------------------------------------------------------
// lssb_dp
// Datapath: window test, slope test, squared distance test, saturating
// gray sum, best-line tracking and the result register.
// ----------------------------------------------------------------------------
module lssb_dp #(
    parameter int MAX_DIM   = lssb_pkg::MAX_DIM,
    parameter int MAX_LINES = lssb_pkg::MAX_LINES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lssb_pkg::t_cfg                      i_cfg,
    input  lssb_pkg::t_cmd                      i_cmd,
    output lssb_pkg::t_sts                      o_sts,
    input  logic [lssb_pkg::COORD_W-1:0]        i_pixel_col,
    input  logic [lssb_pkg::COORD_W-1:0]        i_pixel_row,
    input  logic [lssb_pkg::GRAY_W-1:0]         i_pixel_gray,
    input  logic                                i_new_set,
    input  logic                                i_last_pixel,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [lssb_pkg::SCORE_W-1:0]        o_line_score,
    output logic                                o_slope_rejected,
    output logic [lssb_pkg::SCORE_W-1:0]        o_best_score,
    output logic [lssb_pkg::INDEX_W-1:0]        o_best_index,
    output logic                                o_best_valid
);

    localparam int SW = lssb_pkg::SCORE_W;
    localparam int IW = lssb_pkg::INDEX_W;

    // Captured pixel
    logic [lssb_pkg::GRAY_W-1:0]  r_gray;
    logic                         r_last;
    logic                         r_win;
    logic signed [10:0]           r_dx;
    logic signed [10:0]           r_dy;
    logic signed [10:0]           r_drow;
    logic signed [10:0]           r_dcol;
    logic [lssb_pkg::THICK_W-1:0] r_thick;

    // First multiply step
    logic signed [21:0] r_p1;
    logic signed [21:0] r_p2;
    logic [19:0]        r_dx2;
    logic [19:0]        r_dy2;
    logic [23:0]        r_tt;
    logic [24:0]        r_lo;
    logic [28:0]        r_hi;
    logic signed [10:0] r_ndy;
    logic               r_dxz;

    // Second step
    logic [20:0] r_mag;
    logic [20:0] r_s;
    logic        r_ok;

    // Third step
    logic [49:0] r_lhs;
    logic [44:0] r_rhs;

    // Pass and set state
    logic [SW-1:0] r_score;
    logic [SW-1:0] r_best_sum;
    logic [IW-1:0] r_best_idx;
    logic [IW-1:0] r_pass;
    logic          r_best_found;

    // Result register
    logic          r_out_valid;
    logic [SW-1:0] r_out_line;
    logic          r_out_rej;
    logic [SW-1:0] r_out_best;
    logic [IW-1:0] r_out_idx;
    logic          r_out_found;

    // Combinational helpers
    logic [lssb_pkg::COORD_W-1:0] w_cmin;
    logic [lssb_pkg::COORD_W-1:0] w_rmin;
    logic                         w_win;
    logic signed [21:0]           w_dx2;
    logic signed [21:0]           w_dy2;
    logic [9:0]                   w_ax;
    logic signed [10:0]           w_ady;
    logic signed [22:0]           w_e;
    logic [22:0]                  w_mag;
    logic [28:0]                  w_dy16;
    logic [41:0]                  w_mag2;
    logic [SW:0]                  w_sum;
    logic [SW-1:0]                w_pass_score;
    logic                         w_better;
    logic [IW:0]                  w_pass_inc;
    logic [IW-1:0]                w_pass_next;

    // Pixel window: lower-left corner of the line and image bounds
    always_comb begin
        w_cmin = (i_cfg.x_start < i_cfg.x_end) ? i_cfg.x_start : i_cfg.x_end;
        w_rmin = (i_cfg.y_start < i_cfg.y_end) ? i_cfg.y_start : i_cfg.y_end;
        w_win  = ({1'b0, i_pixel_col} < i_cfg.width)
              && ({1'b0, i_pixel_row} < i_cfg.height)
              && (32'(i_pixel_col) < MAX_DIM)
              && (32'(i_pixel_row) < MAX_DIM)
              && (i_pixel_col >= w_cmin)
              && (i_pixel_row >= w_rmin);
    end

    // Capture the pixel and the line geometry
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_gray  <= i_pixel_gray;
            r_last  <= i_last_pixel;
            r_win   <= w_win;
            r_dx    <= $signed({1'b0, i_cfg.x_end}) - $signed({1'b0, i_cfg.x_start});
            r_dy    <= $signed({1'b0, i_cfg.y_end}) - $signed({1'b0, i_cfg.y_start});
            r_drow  <= $signed({1'b0, i_pixel_row}) - $signed({1'b0, i_cfg.y_start});
            r_dcol  <= $signed({1'b0, i_pixel_col}) - $signed({1'b0, i_cfg.x_start});
            r_thick <= i_cfg.thickness;
        end
    end

    // Step one: cross products, squares and tangent bounds
    always_comb begin
        w_dx2 = r_dx * r_dx;
        w_dy2 = r_dy * r_dy;
        w_ax  = r_dx[10] ? 10'(-r_dx) : r_dx[9:0];
        w_ady = r_dx[10] ? -r_dy : r_dy;
    end

    always_ff @(posedge i_clk) begin
        r_p1  <= r_dx * r_drow;
        r_p2  <= r_dy * r_dcol;
        r_dx2 <= w_dx2[19:0];
        r_dy2 <= w_dy2[19:0];
        r_tt  <= 24'(r_thick) * 24'(r_thick);
        r_lo  <= 25'(lssb_pkg::TAN15_Q16) * 25'(w_ax);
        r_hi  <= 29'(lssb_pkg::TAN80_Q16) * 29'(w_ax);
        r_ndy <= w_ady;
        r_dxz <= (r_dx == '0);
    end

    // Step two: distance magnitude, squared length, slope decision
    always_comb begin
        w_e    = 23'(r_p1) - 23'(r_p2);
        w_mag  = w_e[22] ? 23'(-w_e) : 23'(w_e);
        w_dy16 = {3'b000, r_ndy[9:0], 16'd0};
    end

    always_ff @(posedge i_clk) begin
        r_mag <= w_mag[20:0];
        r_s   <= 21'(r_dx2) + 21'(r_dy2);
        r_ok  <= !r_dxz && !r_ndy[10] && (r_ndy != '0)
              && (w_dy16 >= 29'(r_lo)) && (w_dy16 <= r_hi);
    end

    // Step three: both sides of the squared distance test
    assign w_mag2 = 42'(r_mag) * 42'(r_mag);

    always_ff @(posedge i_clk) begin
        r_lhs <= {w_mag2, 8'd0};
        r_rhs <= 45'(r_tt) * 45'(r_s);
    end

    // Saturating sum and pass close-out
    always_comb begin
        w_sum        = {1'b0, r_score} + (SW+1)'(r_gray);
        w_pass_score = r_ok ? r_score : '0;
        w_better     = w_pass_score > r_best_sum;
        w_pass_inc   = {1'b0, r_pass} + (IW+1)'(1);
        w_pass_next  = (32'(w_pass_inc) == MAX_LINES) ? '0 : w_pass_inc[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score      <= '0;
            r_best_sum   <= '0;
            r_best_idx   <= '0;
            r_pass       <= '0;
            r_best_found <= 1'b0;
        end else begin
            // clear the set ahead of this pixel
            if (i_cmd.capture && i_new_set) begin
                r_best_sum   <= '0;
                r_best_idx   <= '0;
                r_pass       <= '0;
                r_best_found <= 1'b0;
            end
            // add the gray value when the pixel lies on the line
            if (i_cmd.accum && r_win && r_ok && (50'(r_rhs) >= r_lhs)) begin
                r_score <= w_sum[SW] ? lssb_pkg::SCORE_MAX : w_sum[SW-1:0];
            end
            // close the pass
            if (i_cmd.finish) begin
                if (w_better) begin
                    r_best_sum   <= w_pass_score;
                    r_best_idx   <= r_pass;
                    r_best_found <= 1'b1;
                end
                r_pass  <= w_pass_next;
                r_score <= '0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_line  <= w_pass_score;
            r_out_rej   <= !r_ok;
            r_out_best  <= w_better ? w_pass_score : r_best_sum;
            r_out_idx   <= w_better ? r_pass : r_best_idx;
            r_out_found <= w_better | r_best_found;
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_line_score     = r_out_line;
    assign o_slope_rejected = r_out_rej;
    assign o_best_score     = r_out_best;
    assign o_best_index     = r_out_idx;
    assign o_best_valid     = r_out_found;

endmodule

@@ design/line_support_score_best.sv @@
// ----------------------------------------------------------------------------
// line_support_score_best
// Scores one candidate line per pass over a gray image and tracks the best.
// ----------------------------------------------------------------------------
// Each pixel runs from acceptance through the states MUL1, MUL2, MUL3 and
// ACC before the block is ready again; the last pixel of a pass also goes
// through FIN, which waits until the result register is free. The MUL
// states follow the datapath's three-step multiply chain (cross products,
// distance magnitude and squared length, both sides of the distance test),
// ACC accumulates, and FIN closes the pass and loads the result register.
// One result appears per pass, on the pixel flagged last_pixel. Load the
// line and image registers between pixels only while the block is idle.
module line_support_score_best #(
    parameter int MAX_DIM   = lssb_pkg::MAX_DIM,
    parameter int MAX_LINES = lssb_pkg::MAX_LINES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [lssb_pkg::COORD_W-1:0]        i_pixel_col,
    input  logic [lssb_pkg::COORD_W-1:0]        i_pixel_row,
    input  logic [lssb_pkg::GRAY_W-1:0]         i_pixel_gray,
    input  logic                                i_new_set,
    input  logic                                i_last_pixel,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [lssb_pkg::SCORE_W-1:0]        o_line_score,
    output logic                                o_slope_rejected,
    output logic [lssb_pkg::SCORE_W-1:0]        o_best_score,
    output logic [lssb_pkg::INDEX_W-1:0]        o_best_index,
    output logic                                o_best_valid,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lssb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lssb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    lssb_pkg::t_cfg w_cfg;
    lssb_pkg::t_cmd w_cmd;
    lssb_pkg::t_sts w_sts;

    // Register file
    lssb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Sequencer
    lssb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    // Datapath
    lssb_dp #(
        .MAX_DIM   (MAX_DIM),
        .MAX_LINES (MAX_LINES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_pixel_col      (i_pixel_col),
        .i_pixel_row      (i_pixel_row),
        .i_pixel_gray     (i_pixel_gray),
        .i_new_set        (i_new_set),
        .i_last_pixel     (i_last_pixel),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_line_score     (o_line_score),
        .o_slope_rejected (o_slope_rejected),
        .o_best_score     (o_best_score),
        .o_best_index     (o_best_index),
        .o_best_valid     (o_best_valid)
    );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks line_support_score_best with directed and random passes of pixels.
// A cycle-free predictor scores each pass when its last pixel is accepted.
// Both channels are paced at random, and the output channel is held off once
// for a long stretch so that the block must stall its pixel input.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_ITEMS  = 900;

    localparam int COORD_W    = lssb_pkg::COORD_W;
    localparam int GRAY_W     = lssb_pkg::GRAY_W;
    localparam int SCORE_W    = lssb_pkg::SCORE_W;
    localparam int INDEX_W    = lssb_pkg::INDEX_W;
    localparam int CFG_IDX_W  = lssb_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = lssb_pkg::CFG_DATA_W;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [GRAY_W-1:0]  gray;
        logic               new_set;
        logic               last_pixel;
    } t_pixel;

    typedef struct packed {
        logic [SCORE_W-1:0] line_score;
        logic               slope_rejected;
        logic [SCORE_W-1:0] best_score;
        logic [INDEX_W-1:0] best_index;
        logic               best_valid;
    } t_pass_result;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_valid          = 1'b0;
    logic                  o_ready;
    logic [COORD_W-1:0]    i_pixel_col      = '0;
    logic [COORD_W-1:0]    i_pixel_row      = '0;
    logic [GRAY_W-1:0]     i_pixel_gray     = '0;
    logic                  i_new_set        = 1'b0;
    logic                  i_last_pixel     = 1'b0;
    logic                  o_valid;
    logic                  i_ready          = 1'b0;
    logic [SCORE_W-1:0]    o_line_score;
    logic                  o_slope_rejected;
    logic [SCORE_W-1:0]    o_best_score;
    logic [INDEX_W-1:0]    o_best_index;
    logic                  o_best_valid;
    logic                  i_cfg_valid      = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;

    // Register copies, as the block holds them
    int line_xs, line_ys, line_xe, line_ye;
    int thick, img_w, img_h;

    // Pass and set state of the predictor
    longint run_sum, top_sum;
    int     top_index, pass_num;
    bit     top_found;

    t_pass_result expected_passes[$];

    int errors;
    int pixels_sent;
    int passes_checked;
    int passes_rejected;
    int random_items;
    int cycle_count;
    int burst_left;
    int long_stall_req;
    int long_stall_seen;

    line_support_score_best u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_pixel_col      (i_pixel_col),
        .i_pixel_row      (i_pixel_row),
        .i_pixel_gray     (i_pixel_gray),
        .i_new_set        (i_new_set),
        .i_last_pixel     (i_last_pixel),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_line_score     (o_line_score),
        .o_slope_rejected (o_slope_rejected),
        .o_best_score     (o_best_score),
        .o_best_index     (o_best_index),
        .o_best_valid     (o_best_valid),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d passes outstanding", $time,
                     expected_passes.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Accept only lines between 15 and 80 degrees, compared on Q16 tangents
    function automatic bit slope_accepts();
        longint dx, dy;
        dx = line_xe - line_xs;
        dy = line_ye - line_ys;
        if (dx == 0)
            return 1'b0;
        if (dx < 0) begin
            dx = -dx;
            dy = -dy;
        end
        if (dy <= 0)
            return 1'b0;
        return (dy * 65536 >= lssb_pkg::TAN15_Q16 * dx)
            && (dy * 65536 <= lssb_pkg::TAN80_Q16 * dx);
    endfunction

    // Pixel lies in the image, past the lower-left corner and near the line
    function automatic bit pixel_on_line(int col, int row);
        int     wlim, hlim, rmin, cmin;
        longint dx, dy, err, lhs, rhs;
        wlim = (img_w < lssb_pkg::MAX_DIM) ? img_w : lssb_pkg::MAX_DIM;
        hlim = (img_h < lssb_pkg::MAX_DIM) ? img_h : lssb_pkg::MAX_DIM;
        rmin = (line_ys < line_ye) ? line_ys : line_ye;
        cmin = (line_xs < line_xe) ? line_xs : line_xe;
        if (col >= wlim || row >= hlim || row < rmin || col < cmin)
            return 1'b0;
        dx  = line_xe - line_xs;
        dy  = line_ye - line_ys;
        err = dx * (row - line_ys) - dy * (col - line_xs);
        if (err < 0)
            err = -err;
        lhs = err * err * 256;
        rhs = longint'(thick) * thick * (dx * dx + dy * dy);
        return lhs <= rhs;
    endfunction

    // Advance the pass state by one accepted pixel; queue a result on the last
    task automatic score_pixel(input t_pixel px);
        bit           ok;
        longint       score;
        t_pass_result res;
        ok = slope_accepts();
        if (px.new_set) begin
            top_sum   = 0;
            top_index = 0;
            top_found = 1'b0;
            pass_num  = 0;
        end
        if (ok && pixel_on_line(px.col, px.row)) begin
            run_sum += px.gray;
            if (run_sum > lssb_pkg::SCORE_MAX)
                run_sum = lssb_pkg::SCORE_MAX;
        end
        if (px.last_pixel) begin
            score = ok ? run_sum : 0;
            if (score > top_sum) begin
                top_sum   = score;
                top_index = pass_num;
                top_found = 1'b1;
            end
            pass_num = (pass_num + 1) % lssb_pkg::MAX_LINES;
            run_sum  = 0;
            res.line_score     = SCORE_W'(score);
            res.slope_rejected = !ok;
            res.best_score     = SCORE_W'(top_sum);
            res.best_index     = INDEX_W'(top_index);
            res.best_valid     = top_found;
            if (!ok)
                passes_rejected++;
            expected_passes = {expected_passes, res};
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: check each transaction and pace i_ready
    // ------------------------------------------------------------------------
    function automatic void compare_field(string what, logic [31:0] want,
                                          logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what,
                     want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_pass_result want;
        int           pick;
        int           stall_left;
        int           run_left;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_passes.size() == 0) begin
                errors++;
                $display("%0t: result with no pass outstanding, actual score %0d",
                         $time, o_line_score);
            end else begin
                want = expected_passes.pop_front();
                compare_field("line_score", want.line_score, o_line_score);
                compare_field("slope_rejected", want.slope_rejected, o_slope_rejected);
                compare_field("best_score", want.best_score, o_best_score);
                compare_field("best_index", want.best_index, o_best_index);
                compare_field("best_valid", want.best_valid, o_best_valid);
                passes_checked++;
            end
        end
        // Pick up a long hold-off request from the stimulus
        if (long_stall_req != long_stall_seen) begin
            long_stall_seen = long_stall_req;
            stall_left      = LONG_HOLD;
            run_left        = 0;
        end
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else if (run_left > 0) begin
            i_ready <= 1'b1;
            run_left--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                i_ready  <= 1'b1;
                run_left = $urandom_range(0, 6);
            end else if (pick < 70) begin
                i_ready  <= 1'b1;
                run_left = $urandom_range(20, 60);
            end else if (pick < 95) begin
                i_ready    <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                i_ready    <= 1'b0;
                stall_left = $urandom_range(10, 40);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Gap before the next pixel: mostly none or short, a few long, some bursts
    function automatic int pixel_gap();
        int pick;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (pick < 50)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 9);
        return $urandom_range(15, 40);
    endfunction

    function automatic t_pixel make_pixel(int col, int row, int gray, bit ns, bit lst);
        t_pixel px;
        px.col        = COORD_W'(col);
        px.row        = COORD_W'(row);
        px.gray       = GRAY_W'(gray);
        px.new_set    = ns;
        px.last_pixel = lst;
        return px;
    endfunction

    // Send one pixel transaction; hold valid into the next one when more follow
    task automatic send_pixel(input t_pixel px, input bit more);
        int gap;
        i_valid      <= 1'b1;
        i_pixel_col  <= px.col;
        i_pixel_row  <= px.row;
        i_pixel_gray <= px.gray;
        i_new_set    <= px.new_set;
        i_last_pixel <= px.last_pixel;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        score_pixel(px);
        pixels_sent++;
        gap = pixel_gap();
        if (!more && gap == 0)
            gap = 1;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait until every pass is out and the datapath has drained
    task automatic wait_quiet();
        while (expected_passes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            lssb_pkg::REG_X_START:   line_xs = value & 'h3FF;
            lssb_pkg::REG_Y_START:   line_ys = value & 'h3FF;
            lssb_pkg::REG_X_END:     line_xe = value & 'h3FF;
            lssb_pkg::REG_Y_END:     line_ye = value & 'h3FF;
            lssb_pkg::REG_THICKNESS: thick   = value & 'hFFF;
            lssb_pkg::REG_WIDTH:     img_w   = value & 'h7FF;
            lssb_pkg::REG_HEIGHT:    img_h   = value & 'h7FF;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Load both endpoints; unused upper data bits carry junk
    task automatic set_line(input int xs, input int ys, input int xe, input int ye);
        int junk;
        junk = $urandom_range(0, 3);
        write_reg(lssb_pkg::REG_X_START, xs | (junk << COORD_W));
        junk = $urandom_range(0, 3);
        write_reg(lssb_pkg::REG_Y_START, ys | (junk << COORD_W));
        junk = $urandom_range(0, 3);
        write_reg(lssb_pkg::REG_X_END, xe | (junk << COORD_W));
        junk = $urandom_range(0, 3);
        write_reg(lssb_pkg::REG_Y_END, ye | (junk << COORD_W));
    endtask

    task automatic set_image(input int th, input int w, input int h);
        write_reg(lssb_pkg::REG_THICKNESS, th);
        write_reg(lssb_pkg::REG_WIDTH, w);
        write_reg(lssb_pkg::REG_HEIGHT, h);
    endtask

    task automatic one_pixel_pass(input int col, input int row, input int gray,
                                  input bit ns);
        send_pixel(make_pixel(col, row, gray, ns, 1'b1), 1'b0);
    endtask

    function automatic int pick_dim();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return lssb_pkg::MAX_DIM;
        if (pick < 80)
            return $urandom_range(lssb_pkg::MAX_DIM + 1, 2047);
        return $urandom_range(0, lssb_pkg::MAX_DIM - 1);
    endfunction

    function automatic int pick_thickness();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(4, 80);
        if (pick < 90)
            return $urandom_range(0, 4095);
        return (pick < 95) ? 0 : 4095;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset registers give a degenerate line: the pass is rejected
    task automatic test_reset_state();
        send_pixel(make_pixel(5, 5, 7, 1'b1, 1'b0), 1'b1);
        send_pixel(make_pixel(10, 10, 255, 1'b0, 1'b1), 1'b0);
    endtask

    // Field and register extremes, widest and zero thickness
    task automatic test_field_extremes();
        set_image(4095, 2047, 1024);
        set_line(0, 0, 1023, 1023);
        send_pixel(make_pixel(0, 0, 255, 1'b1, 1'b0), 1'b1);
        send_pixel(make_pixel(1023, 1023, 255, 1'b0, 1'b0), 1'b1);
        send_pixel(make_pixel(1023, 0, 128, 1'b0, 1'b0), 1'b1);
        send_pixel(make_pixel(0, 1023, 0, 1'b0, 1'b1), 1'b0);
        set_image(0, 1024, 1024);
        send_pixel(make_pixel(512, 512, 255, 1'b0, 1'b0), 1'b1);
        send_pixel(make_pixel(513, 512, 200, 1'b0, 1'b1), 1'b0);
    endtask

    // Vertical, horizontal, falling, reversed, zero-length and both edges of the window
    task automatic test_slope_limits();
        int lines [9][4] = '{
            '{100, 100, 100, 500},
            '{100, 100, 500, 100},
            '{100, 500, 500, 100},
            '{0, 0, 1000, 268},
            '{0, 0, 1000, 267},
            '{0, 0, 180, 1020},
            '{0, 0, 180, 1021},
            '{600, 700, 200, 300},
            '{300, 300, 300, 300}
        };
        set_image(32, 1024, 1024);
        foreach (lines[k]) begin
            set_line(lines[k][0], lines[k][1], lines[k][2], lines[k][3]);
            one_pixel_pass((lines[k][0] + lines[k][2]) / 2,
                           (lines[k][1] + lines[k][3]) / 2, 200, 1'b0);
        end
    endtask

    // Equal scores keep the earlier best; a zero score never marks a best
    task automatic test_ties_and_sets();
        set_line(0, 0, 100, 100);
        one_pixel_pass(10, 10, 100, 1'b1);
        one_pixel_pass(20, 20, 100, 1'b0);
        one_pixel_pass(30, 30, 0, 1'b0);
        one_pixel_pass(90, 10, 255, 1'b1);
        one_pixel_pass(50, 50, 60, 1'b0);
    endtask

    // Zero width or height counts no pixel but does not reject the line
    task automatic test_zero_image();
        set_image(32, 0, 1024);
        one_pixel_pass(40, 40, 90, 1'b0);
        set_image(32, 1024, 0);
        one_pixel_pass(40, 40, 90, 1'b0);
        set_image(32, 1024, 1024);
    endtask

    // Thickness changed between two pixels of one pass
    task automatic test_mid_pass_config();
        set_image(0, 1024, 1024);
        send_pixel(make_pixel(50, 52, 10, 1'b0, 1'b0), 1'b0);
        write_reg(lssb_pkg::REG_THICKNESS, 64);
        send_pixel(make_pixel(50, 52, 20, 1'b0, 1'b1), 1'b0);
    endtask

    // Run one set past 256 passes so the pass number wraps
    task automatic test_pass_wrap();
        set_image(16, 1024, 1024);
        set_line(0, 0, 1000, 1000);
        for (int k = 0; k < lssb_pkg::MAX_LINES; k++)
            send_pixel(make_pixel(k, k, k, k == 0, 1'b1), 1'b1);
        send_pixel(make_pixel(256, 256, 200, 1'b0, 1'b0), 1'b1);
        send_pixel(make_pixel(257, 257, 200, 1'b0, 1'b1), 1'b1);
        send_pixel(make_pixel(258, 258, 255, 1'b0, 1'b1), 1'b0);
    endtask

    // Hold the output off while short passes keep coming
    task automatic test_output_hold_off();
        int gray;
        set_line(0, 0, 500, 300);
        long_stall_req++;
        for (int p = 0; p < 6; p++) begin
            for (int j = 0; j < 3; j++) begin
                gray = $urandom_range(0, 255);
                send_pixel(make_pixel(50 * (p + j), 30 * (p + j), gray, p == 0 && j == 0,
                                      j == 2), !(p == 5 && j == 2));
            end
        end
    endtask

    // One random pass: mostly accepted lines and pixels near them
    task automatic random_pass();
        int dx, dy, lo, hi, xs, ys, xe, ye, tmp;
        int len, t, jc, jr, col, row, gray;
        bit ns;
        if ($urandom_range(0, 99) < 80) begin
            dx = $urandom_range(1, 400);
            lo = (lssb_pkg::TAN15_Q16 * dx + 65535) / 65536;
            hi = (lssb_pkg::TAN80_Q16 * dx) / 65536;
            if (hi > 1023)
                hi = 1023;
            dy = $urandom_range(lo, hi);
            xs = $urandom_range(0, 1023 - dx);
            ys = $urandom_range(0, 1023 - dy);
            xe = xs + dx;
            ye = ys + dy;
            if ($urandom_range(0, 1)) begin
                tmp = xs; xs = xe; xe = tmp;
                tmp = ys; ys = ye; ye = tmp;
            end
        end else begin
            xs = $urandom_range(0, 1023);
            ys = $urandom_range(0, 1023);
            xe = $urandom_range(0, 1023);
            ye = $urandom_range(0, 1023);
        end
        set_line(xs, ys, xe, ye);
        if ($urandom_range(0, 3) == 0)
            set_image(pick_thickness(), pick_dim(), pick_dim());
        len = $urandom_range(1, 30);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 70) begin
                t   = $urandom_range(0, 1000);
                jc  = $urandom_range(0, 4);
                jr  = $urandom_range(0, 4);
                col = xs + ((xe - xs) * t) / 1000 + jc - 2;
                row = ys + ((ye - ys) * t) / 1000 + jr - 2;
                col = (col < 0) ? 0 : (col > 1023) ? 1023 : col;
                row = (row < 0) ? 0 : (row > 1023) ? 1023 : row;
            end else begin
                col = $urandom_range(0, 1023);
                row = $urandom_range(0, 1023);
            end
            gray = $urandom_range(0, 255);
            ns   = (k == 0) ? ($urandom_range(0, 4) == 0) : ($urandom_range(0, 49) == 0);
            send_pixel(make_pixel(col, row, gray, ns, k == len - 1), k != len - 1);
            random_items++;
        end
    endtask

    task automatic test_random_passes();
        set_image(32, 1024, 1024);
        while (random_items < RANDOM_ITEMS)
            random_pass();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        line_xs   = 0;
        line_ys   = 0;
        line_xe   = 0;
        line_ye   = 0;
        thick     = lssb_pkg::THICK_RESET;
        img_w     = lssb_pkg::DIM_RESET;
        img_h     = lssb_pkg::DIM_RESET;
        run_sum   = 0;
        top_sum   = 0;
        top_index = 0;
        pass_num  = 0;
        top_found = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_field_extremes();
        test_slope_limits();
        test_ties_and_sets();
        test_zero_image();
        test_mid_pass_config();
        test_pass_wrap();
        test_output_hold_off();
        test_random_passes();

        wait_quiet();
        $display("run covered %0d pixels and %0d scored passes, %0d of them slope-rejected,",
                 pixels_sent, passes_checked, passes_rejected);
        $display("including a pass-number wrap and a %0d-cycle output hold-off", LONG_HOLD);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
